@@ rtl/core/todpt_pkg.sv @@
package todpt_pkg;

  // Day and channel limits
  localparam int unsigned HOURS_PER_DAY = 24;
  localparam int unsigned MAX_MINUTE    = 59;
  localparam int unsigned CHANNEL_MAX   = 31;
  localparam int unsigned TINT_SHIFT    = 8;

  // Reciprocal of sixty, scaled by 2^20: exact for every product below 2^13
  localparam int unsigned RECIP_60      = 17477;
  localparam int unsigned RECIP_SHIFT   = 20;

  // Register indexes on the configuration port
  localparam logic [1:0] REG_OVERRIDE_ENABLE = 2'd0;
  localparam logic [1:0] REG_OVERRIDE_HOUR   = 2'd1;
  localparam logic [1:0] REG_OVERRIDE_MINUTE = 2'd2;

  // Channel indexes inside a tint set
  localparam int unsigned CH_RED   = 0;
  localparam int unsigned CH_GREEN = 1;
  localparam int unsigned CH_BLUE  = 2;

  typedef struct packed {
    logic [4:0]  clock_hour;
    logic [5:0]  clock_minute;
    logic [14:0] source_color;
  } in_item_t;

  typedef struct packed {
    logic [14:0] tinted_color;
    logic        skipped;
  } out_item_t;

  // Q1.8 tints, element CH_RED .. CH_BLUE
  typedef logic [2:0][8:0] tint_set_t;

  function automatic tint_set_t mk_tint(input logic [8:0] r, input logic [8:0] g,
                                        input logic [8:0] b);
    tint_set_t t;
    t[CH_RED]   = r;
    t[CH_GREEN] = g;
    t[CH_BLUE]  = b;
    return t;
  endfunction

  // Hourly tint table; hour is already folded into 0..23
  function automatic tint_set_t tint_rom(input logic [4:0] hour);
    tint_set_t t;
    case (hour)
      5'd0, 5'd1, 5'd2, 5'd3:   t = mk_tint(9'd153, 9'd153, 9'd235);
      5'd4:                     t = mk_tint(9'd153, 9'd166, 9'd256);
      5'd5, 5'd6, 5'd7:         t = mk_tint(9'd179, 9'd179, 9'd230);
      5'd8:                     t = mk_tint(9'd230, 9'd217, 9'd256);
      5'd9:                     t = mk_tint(9'd256, 9'd230, 9'd256);
      5'd17:                    t = mk_tint(9'd256, 9'd250, 9'd230);
      5'd18:                    t = mk_tint(9'd230, 9'd179, 9'd171);
      5'd19:                    t = mk_tint(9'd192, 9'd168, 9'd197);
      5'd20:                    t = mk_tint(9'd179, 9'd161, 9'd209);
      5'd21, 5'd22, 5'd23:      t = mk_tint(9'd153, 9'd153, 9'd235);
      default:                  t = mk_tint(9'd256, 9'd256, 9'd256);
    endcase
    return t;
  endfunction

endpackage

@@ rtl/core/time_of_day_palette_tint.sv @@
// Tints one RGB555 colour per clock for the time of day. A beat is taken on
// every cycle with start high (busy is always low) and its result appears on
// out_item with out_strobe high for one cycle, in order, after passing the
// five register stages (table lookup, minute product, divide by sixty by
// reciprocal, blend, channel scale and clamp). The receiver cannot stall the
// block. Configuration writes are always taken (cfg_ready high) and apply to
// beats accepted after the write.
module time_of_day_palette_tint (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  todpt_pkg::in_item_t  in_item,
  output logic                 out_strobe,
  output todpt_pkg::out_item_t out_item,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [1:0]           cfg_index,
  input  logic [5:0]           cfg_data
);

  // Configuration registers
  logic       ovr_en_r;
  logic [4:0] ovr_hour_r;
  logic [5:0] ovr_min_r;

  // Stage 1: lookup
  logic              v1_r;
  logic [14:0]       color1_r;
  logic [5:0]        min1_r;
  logic [8:0]        cur1_r  [3];
  logic signed [9:0] diff1_r [3];

  // Stage 2: minute product magnitude
  logic        v2_r;
  logic [14:0] color2_r;
  logic [8:0]  cur2_r [3];
  logic        neg2_r [3];
  logic [12:0] mag2_r [3];

  // Stage 3: quotient by sixty
  logic        v3_r;
  logic [14:0] color3_r;
  logic [8:0]  cur3_r [3];
  logic        neg3_r [3];
  logic [7:0]  q3_r   [3];

  // Stage 4: blended tint
  logic        v4_r;
  logic [14:0] color4_r;
  logic [8:0]  blend4_r [3];

  // Stage 5: output
  logic                 out_strobe_r;
  todpt_pkg::out_item_t out_item_r;

  // Combinational signals
  logic                 accept;
  logic [4:0]           hour_sel;
  logic [5:0]           min_sel;
  logic [4:0]           hour_fix;
  logic [5:0]           min_fix;
  logic [4:0]           hour_next;
  todpt_pkg::tint_set_t tint_cur;
  todpt_pkg::tint_set_t tint_nxt;
  logic signed [16:0]   prod2 [3];
  logic [16:0]          abs2  [3];
  logic [27:0]          qfull [3];
  logic signed [9:0]    sum4  [3];
  logic [13:0]          scale5 [3];
  logic [4:0]           ch5    [3];
  logic [14:0]          tinted_nxt;

  assign busy      = 1'b0;
  assign cfg_ready = 1'b1;
  assign accept    = start && !busy;

  // Hold configuration
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovr_en_r   <= 1'b0;
      ovr_hour_r <= '0;
      ovr_min_r  <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        todpt_pkg::REG_OVERRIDE_ENABLE: ovr_en_r   <= cfg_data[0];
        todpt_pkg::REG_OVERRIDE_HOUR:   ovr_hour_r <= cfg_data[4:0];
        todpt_pkg::REG_OVERRIDE_MINUTE: ovr_min_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Select time, fold hour into a day, saturate minute, look up both hours
  always_comb begin
    hour_sel  = ovr_en_r ? ovr_hour_r : in_item.clock_hour;
    min_sel   = ovr_en_r ? ovr_min_r : in_item.clock_minute;
    hour_fix  = (hour_sel >= 5'(todpt_pkg::HOURS_PER_DAY))
                ? hour_sel - 5'(todpt_pkg::HOURS_PER_DAY) : hour_sel;
    min_fix   = (min_sel > 6'(todpt_pkg::MAX_MINUTE))
                ? 6'(todpt_pkg::MAX_MINUTE) : min_sel;
    hour_next = (hour_fix == 5'(todpt_pkg::HOURS_PER_DAY - 1)) ? '0 : hour_fix + 5'd1;
    tint_cur  = todpt_pkg::tint_rom(hour_fix);
    tint_nxt  = todpt_pkg::tint_rom(hour_next);
  end

  // Per-channel arithmetic of stages 2 to 5
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      prod2[c]  = 17'(diff1_r[c]) * $signed({11'b0, min1_r});
      abs2[c]   = prod2[c][16] ? 17'(-prod2[c]) : 17'(prod2[c]);
      qfull[c]  = 28'(mag2_r[c]) * 28'(todpt_pkg::RECIP_60);
      sum4[c]   = $signed({1'b0, cur3_r[c]})
                + (neg3_r[c] ? -$signed({2'b0, q3_r[c]}) : $signed({2'b0, q3_r[c]}));
      scale5[c] = 14'(color4_r[5*c +: 5]) * 14'(blend4_r[c]);
      ch5[c]    = (scale5[c][13:todpt_pkg::TINT_SHIFT] > 6'(todpt_pkg::CHANNEL_MAX))
                  ? 5'(todpt_pkg::CHANNEL_MAX) : scale5[c][12:todpt_pkg::TINT_SHIFT];
    end
    tinted_nxt = {ch5[todpt_pkg::CH_BLUE], ch5[todpt_pkg::CH_GREEN], ch5[todpt_pkg::CH_RED]};
  end

  // Advance valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r         <= 1'b0;
      v2_r         <= 1'b0;
      v3_r         <= 1'b0;
      v4_r         <= 1'b0;
      out_strobe_r <= 1'b0;
    end else begin
      v1_r         <= accept;
      v2_r         <= v1_r;
      v3_r         <= v2_r;
      v4_r         <= v3_r;
      out_strobe_r <= v4_r;
    end
  end

  // Advance payload
  always_ff @(posedge clk) begin
    color1_r <= in_item.source_color;
    min1_r   <= min_fix;
    color2_r <= color1_r;
    color3_r <= color2_r;
    color4_r <= color3_r;
    for (int c = 0; c < 3; c++) begin
      cur1_r[c]   <= tint_cur[c];
      diff1_r[c]  <= $signed({1'b0, tint_nxt[c]}) - $signed({1'b0, tint_cur[c]});
      cur2_r[c]   <= cur1_r[c];
      neg2_r[c]   <= prod2[c][16];
      mag2_r[c]   <= abs2[c][12:0];
      cur3_r[c]   <= cur2_r[c];
      neg3_r[c]   <= neg2_r[c];
      q3_r[c]     <= qfull[c][todpt_pkg::RECIP_SHIFT +: 8];
      blend4_r[c] <= sum4[c][8:0];
    end
    out_item_r.tinted_color <= tinted_nxt;
    out_item_r.skipped      <= (color4_r == '0);
  end

  assign out_strobe = out_strobe_r;
  assign out_item   = out_item_r;

  // Every accepted beat yields a result strobe
  assert property (@(posedge clk) disable iff (!rst_n)
    accept |-> ##5 out_strobe)
    else $error("result missing five cycles after accepted beat");

  // A skipped colour leaves black
  assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.skipped) |-> (out_item.tinted_color == '0))
    else $error("skipped result is not black");

  // No strobe without a beat in flight
  assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> $past(v4_r))
    else $error("result strobe without a beat in flight");

endmodule

@@ tb/tb_time_of_day_palette_tint.sv @@
module tb_time_of_day_palette_tint;

  localparam int MINUTES_PER_HOUR = 60;
  localparam int QUIET_LIMIT      = 2000;
  localparam int TAIL_CYCLES      = 12;
  localparam int REPORT_LIMIT     = 10;

  // Track override registers and the tints still owed by the block
  class tint_scoreboard;
    logic                 ovr_enable;
    logic [4:0]           ovr_hour;
    logic [5:0]           ovr_minute;
    todpt_pkg::out_item_t owed_tints[$];
    int                   errors;
    int                   reported;

    function new();
      ovr_enable = 1'b0;
      ovr_hour   = '0;
      ovr_minute = '0;
      errors     = 0;
      reported   = 0;
    endfunction

    function void write_reg(logic [1:0] idx, logic [5:0] data);
      case (idx)
        todpt_pkg::REG_OVERRIDE_ENABLE: ovr_enable = data[0];
        todpt_pkg::REG_OVERRIDE_HOUR:   ovr_hour   = data[4:0];
        todpt_pkg::REG_OVERRIDE_MINUTE: ovr_minute = data;
        default: ;
      endcase
    endfunction

    // Hourly Q1.8 tints, packed as {blue, green, red}
    function todpt_pkg::tint_set_t day_tint(int hr);
      case (hr)
        0, 1, 2, 3:   return {9'd235, 9'd153, 9'd153};
        4:            return {9'd256, 9'd166, 9'd153};
        5, 6, 7:      return {9'd230, 9'd179, 9'd179};
        8:            return {9'd256, 9'd217, 9'd230};
        9:            return {9'd256, 9'd230, 9'd256};
        17:           return {9'd230, 9'd250, 9'd256};
        18:           return {9'd171, 9'd179, 9'd230};
        19:           return {9'd197, 9'd168, 9'd192};
        20:           return {9'd209, 9'd161, 9'd179};
        21, 22, 23:   return {9'd235, 9'd153, 9'd153};
        default:      return {3{9'd256}};
      endcase
    endfunction

    function todpt_pkg::out_item_t tint_for_time(todpt_pkg::in_item_t beat);
      todpt_pkg::out_item_t res;
      todpt_pkg::tint_set_t cur_t;
      todpt_pkg::tint_set_t nxt_t;
      int hr;
      int mn;
      int nx;
      int cur;
      int nxt;
      int blend;
      int scaled;
      res = '0;
      // Pass black straight through and flag it
      if (beat.source_color == '0) begin
        res.skipped = 1'b1;
        return res;
      end
      hr = ovr_enable ? int'(ovr_hour) : int'(beat.clock_hour);
      mn = ovr_enable ? int'(ovr_minute) : int'(beat.clock_minute);
      // Fold hours past midnight, saturate minutes
      if (hr >= todpt_pkg::HOURS_PER_DAY) hr = hr - todpt_pkg::HOURS_PER_DAY;
      if (mn > todpt_pkg::MAX_MINUTE) mn = todpt_pkg::MAX_MINUTE;
      nx = (hr + 1 >= todpt_pkg::HOURS_PER_DAY) ? 0 : hr + 1;
      cur_t = day_tint(hr);
      nxt_t = day_tint(nx);
      for (int c = 0; c < 3; c++) begin
        cur = int'(cur_t[c]);
        nxt = int'(nxt_t[c]);
        // Signed divide truncates toward zero
        blend  = cur + ((nxt - cur) * mn) / MINUTES_PER_HOUR;
        scaled = (int'(beat.source_color[5*c +: 5]) * (blend & 'h1FF))
                 >> todpt_pkg::TINT_SHIFT;
        if (scaled > todpt_pkg::CHANNEL_MAX) scaled = todpt_pkg::CHANNEL_MAX;
        res.tinted_color[5*c +: 5] = scaled[4:0];
      end
      return res;
    endfunction

    function void note_beat(todpt_pkg::in_item_t beat);
      owed_tints.push_back(tint_for_time(beat));
    endfunction

    function void check_result(todpt_pkg::out_item_t got);
      todpt_pkg::out_item_t want;
      if (owed_tints.size() == 0) begin
        errors++;
        if (reported < REPORT_LIMIT)
          $display("unexpected result: colour %h skipped %b", got.tinted_color, got.skipped);
        reported++;
        return;
      end
      want = owed_tints.pop_front();
      if (got.tinted_color !== want.tinted_color || got.skipped !== want.skipped) begin
        errors++;
        if (reported < REPORT_LIMIT)
          $display("mismatch: expected colour %h skipped %b, got colour %h skipped %b",
                   want.tinted_color, want.skipped, got.tinted_color, got.skipped);
        reported++;
      end
    endfunction

    function int pending();
      return owed_tints.size();
    endfunction

    // Count every result that never turned up
    function void close_out();
      if (owed_tints.size() != 0) begin
        errors += owed_tints.size();
        $display("%0d expected results never arrived", owed_tints.size());
      end
    endfunction
  endclass

  logic                 clk;
  logic                 rst_n;
  logic                 start;
  logic                 busy;
  todpt_pkg::in_item_t  in_item;
  logic                 out_strobe;
  todpt_pkg::out_item_t out_item;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [1:0]           cfg_index;
  logic [5:0]           cfg_data;

  tint_scoreboard sb;
  int gap_pct      = 0;
  int quiet_cycles = 0;

  time_of_day_palette_tint DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .start      (start),
    .busy       (busy),
    .in_item    (in_item),
    .out_strobe (out_strobe),
    .out_item   (out_item),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // Check every strobed result against the oldest owed tint
  always @(posedge clk) begin
    if (rst_n && out_strobe) begin
      sb.check_result(out_item);
      quiet_cycles = 0;
    end
  end

  // End the run when nothing moves for too long
  initial begin
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      quiet_cycles++;
    end
    $display("tb_time_of_day_palette_tint NOT OK");
    $finish;
  end

  // Offer one beat after a random gap; hold it until taken
  task automatic send_beat(todpt_pkg::in_item_t beat);
    while ($urandom_range(99) < gap_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= beat;
    do @(posedge clk); while (busy);
    sb.note_beat(beat);
    quiet_cycles = 0;
  endtask

  task automatic send_fields(logic [4:0] hr, logic [5:0] mn, logic [14:0] color);
    todpt_pkg::in_item_t beat;
    beat.clock_hour   = hr;
    beat.clock_minute = mn;
    beat.source_color = color;
    send_beat(beat);
  endtask

  // Drop start and hold off until every owed tint has come back
  task automatic wait_all_results();
    start <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  task automatic cfg_beat(logic [1:0] idx, logic [5:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, data);
    quiet_cycles = 0;
  endtask

  // Write all three override registers while the block is idle
  task automatic set_override(logic en, logic [4:0] hr, logic [5:0] mn);
    wait_all_results();
    cfg_beat(todpt_pkg::REG_OVERRIDE_ENABLE, {5'd0, en});
    cfg_beat(todpt_pkg::REG_OVERRIDE_HOUR, {1'b0, hr});
    cfg_beat(todpt_pkg::REG_OVERRIDE_MINUTE, mn);
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [4:0] random_hour();
    return ($urandom_range(9) == 0) ? 5'($urandom_range(31, 24)) : 5'($urandom_range(23));
  endfunction

  function automatic logic [5:0] random_minute();
    return ($urandom_range(9) == 0) ? 6'($urandom_range(63, 60)) : 6'($urandom_range(59));
  endfunction

  function automatic todpt_pkg::in_item_t random_item();
    todpt_pkg::in_item_t beat;
    beat.clock_hour   = random_hour();
    beat.clock_minute = random_minute();
    case ($urandom_range(9))
      0: beat.source_color = '0;
      1: beat.source_color = {$urandom_range(1) ? 5'd31 : 5'd0,
                              $urandom_range(1) ? 5'd31 : 5'd0,
                              $urandom_range(1) ? 5'd31 : 5'd0};
      default: beat.source_color = 15'($urandom());
    endcase
    return beat;
  endfunction

  initial begin
    int phase_gap [3];
    phase_gap = '{28, 47, 0};
    sb = new();
    rst_n     <= 1'b0;
    start     <= 1'b0;
    in_item   <= '0;
    cfg_valid <= 1'b0;
    cfg_index <= '0;
    cfg_data  <= '0;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Clock time: black, channel extremes, wrap at midnight, folded fields
    send_fields(5'd0, 6'd0, 15'h0000);
    send_fields(5'd23, 6'd59, 15'h0000);
    send_fields(5'd0, 6'd0, 15'h7FFF);
    send_fields(5'd23, 6'd59, 15'h7FFF);
    send_fields(5'd23, 6'd30, 15'h001F);
    send_fields(5'd17, 6'd45, 15'h03E0);
    send_fields(5'd18, 6'd20, 15'h7C00);
    send_fields(5'd24, 6'd0, 15'h7FFF);
    send_fields(5'd31, 6'd63, 15'h7FFF);
    send_fields(5'd8, 6'd60, 15'h5555);
    send_fields(5'd4, 6'd59, 15'h2AAA);
    send_fields(5'd12, 6'd30, 15'h0001);
    send_fields(5'd19, 6'd1, 15'h7FFF);

    // Override time at its extremes, including folded values
    set_override(1'b1, 5'd23, 6'd59);
    send_fields(5'd0, 6'd0, 15'h7FFF);
    send_fields(5'd5, 6'd5, 15'h0000);
    send_fields(5'd31, 6'd63, 15'h1234);
    set_override(1'b1, 5'd31, 6'd63);
    send_fields(5'd0, 6'd0, 15'h7FFF);
    send_fields(5'd12, 6'd30, 15'h03FF);
    set_override(1'b1, 5'd0, 6'd0);
    send_fields(5'd23, 6'd59, 15'h7FFF);
    set_override(1'b0, 5'd0, 6'd0);

    // Random beats in three idling phases, reprogrammed between segments
    for (int p = 0; p < 3; p++) begin
      gap_pct = phase_gap[p];
      for (int seg = 0; seg < 3; seg++) begin
        set_override($urandom_range(2) == 0, random_hour(), random_minute());
        for (int i = 0; i < 110; i++) send_beat(random_item());
      end
    end

    // Drain, then allow for any stray strobes past the pipeline depth
    wait_all_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    sb.close_out();
    if (sb.errors == 0) begin
      $display("tb_time_of_day_palette_tint OK");
    end else begin
      $display("tb_time_of_day_palette_tint NOT OK");
    end
    $finish;
  end

endmodule
